// ===== rtl/tcb_pkg.sv =====
// tcb_pkg: shared types and constants for the text cell blitter.
// Holds item kinds, register indexes, sequencer states and the structs
// passed between the engine, the cell store and the top level.
`timescale 1ns / 1ps

package tcb_pkg;

    // Index width: row * columns + column stays below 2**16 for all geometries
    localparam int IDX_W  = 16;
    localparam int CELL_W = 16;
    localparam int CHG_W  = 14;
    localparam int CNT_W  = 32;

    localparam logic [7:0] BLANK_GLYPH = 8'd32;
    localparam logic [7:0] COLS_RESET  = 8'd80;
    localparam logic [6:0] ROWS_RESET  = 7'd25;

    // Item kinds
    typedef enum logic [2:0] {
        KIND_PUT    = 3'd0,
        KIND_FILL   = 3'd1,
        KIND_SCROLL = 3'd2,
        KIND_READ   = 3'd3,
        KIND_TAKE   = 3'd4
    } kind_t;

    // Configuration register indexes
    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIP,
        ST_MUL_DST,
        ST_MUL_SRC,
        ST_ROW,
        ST_RD,
        ST_WR,
        ST_DONE
    } state_t;

    // Cell store access: one write port, two read ports
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [CELL_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_idx_a;
        logic [IDX_W-1:0]  rd_idx_b;
    } mem_req_t;

    // One result item
    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [CHG_W-1:0]  changed_cells;
        logic [CNT_W-1:0]  total_writes;
    } result_t;

endpackage

// ===== rtl/tcb_store.sv =====
// tcb_store: cell memory, one write port and two registered read ports.
// Depends on tcb_pkg for the access request struct.
`timescale 1ns / 1ps

module tcb_store
    import tcb_pkg::*;
#(
    parameter int CELL_CAPACITY = 4096
) (
    input  logic              clk,
    input  mem_req_t          req,
    output logic [CELL_W-1:0] rd_data_a,
    output logic [CELL_W-1:0] rd_data_b
);

    localparam int AW = $clog2(CELL_CAPACITY);

    logic [CELL_W-1:0] mem [CELL_CAPACITY];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_idx[AW-1:0]] <= req.wr_data;
        end
    end

    // Read ports, data registered
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[req.rd_idx_a[AW-1:0]];
        rd_data_b <= mem[req.rd_idx_b[AW-1:0]];
    end

endmodule

// ===== rtl/tcb_engine.sv =====
// tcb_engine: sequencer that clips each item and walks its cells through
// the store, with one shared multiplier for row bases and a change counter.
// Depends on tcb_pkg; drives the tcb_store request.
`timescale 1ns / 1ps

module tcb_engine
    import tcb_pkg::*;
#(
    parameter int CELL_CAPACITY = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        kind,
    input  logic signed [8:0] x_pos,
    input  logic signed [8:0] y_pos,
    input  logic signed [8:0] rect_width,
    input  logic signed [8:0] rect_height,
    input  logic signed [7:0] scroll_lines,
    input  logic [7:0]        glyph,
    input  logic [7:0]        attribute,
    input  logic [7:0]        cols,
    input  logic [6:0]        rows,
    output mem_req_t          mem_req,
    input  logic [CELL_W-1:0] rd_data_a,
    input  logic [CELL_W-1:0] rd_data_b,
    output logic              res_valid,
    input  logic              res_take,
    output result_t           res
);

    localparam int AW = $clog2(CELL_CAPACITY);
    localparam logic [IDX_W-1:0] CAP_IDX  = IDX_W'(CELL_CAPACITY);
    localparam logic [AW-1:0]    CLR_LAST = AW'(CELL_CAPACITY - 1);

    state_t state_reg, state_next;

    // Captured item
    logic [2:0]        kind_reg,  kind_next;
    logic signed [8:0] xin_reg,   xin_next;
    logic signed [8:0] yin_reg,   yin_next;
    logic signed [8:0] win_reg,   win_next;
    logic signed [8:0] hin_reg,   hin_next;
    logic signed [7:0] lines_reg, lines_next;
    logic [7:0]        glyph_reg, glyph_next;
    logic [7:0]        attr_reg,  attr_next;

    // Clipped walk parameters
    logic [7:0]        xc_reg,     xc_next;
    logic [7:0]        w_reg,      w_next;
    logic [6:0]        h_reg,      h_next;
    logic [7:0]        ystart_reg, ystart_next;
    logic [7:0]        mag_reg,    mag_next;
    logic [6:0]        copy_reg,   copy_next;
    logic              desc_reg,   desc_next;
    logic              read_reg,   read_next;
    logic [CELL_W-1:0] fill_reg,   fill_next;

    // Walk position
    logic [IDX_W-1:0]  dst_base_reg, dst_base_next;
    logic [IDX_W-1:0]  src_base_reg, src_base_next;
    logic [IDX_W-1:0]  dst_idx_reg,  dst_idx_next;
    logic [IDX_W-1:0]  src_idx_reg,  src_idx_next;
    logic [7:0]        col_reg,      col_next;
    logic [6:0]        row_reg,      row_next;

    // Results and counters
    logic [CELL_W-1:0] value_reg,   value_next;
    logic [CHG_W-1:0]  chg_reg,     chg_next;
    logic [CNT_W-1:0]  total_reg,   total_next;
    logic [CNT_W-1:0]  counter_reg, counter_next;
    logic [AW-1:0]     clr_reg,     clr_next;

    // Clipping, from the captured item
    logic              single, scroll, act, part, go;
    logic signed [10:0] xs, ys, ws0, hs0, ws1, hs1, ws2, hs2;
    logic signed [10:0] xc_s, yc_s, cols_s, rows_s, lines_s, mag_s, copy_s, ystart_s;

    always_comb
    begin
        single  = (kind_reg == KIND_PUT) || (kind_reg == KIND_READ);
        scroll  = (kind_reg == KIND_SCROLL);
        xs      = {{2{xin_reg[8]}}, xin_reg};
        ys      = {{2{yin_reg[8]}}, yin_reg};
        ws0     = single ? 11'sd1 : {{2{win_reg[8]}}, win_reg};
        hs0     = single ? 11'sd1 : {{2{hin_reg[8]}}, hin_reg};
        cols_s  = {3'b000, cols};
        rows_s  = {4'b0000, rows};
        lines_s = {{3{lines_reg[7]}}, lines_reg};

        // left and top edges
        if (xs < 11'sd0)
        begin
            ws1  = ws0 + xs;
            xc_s = 11'sd0;
        end
        else
        begin
            ws1  = ws0;
            xc_s = xs;
        end
        if (ys < 11'sd0)
        begin
            hs1  = hs0 + ys;
            yc_s = 11'sd0;
        end
        else
        begin
            hs1  = hs0;
            yc_s = ys;
        end

        // right and bottom edges
        ws2 = (xc_s + ws1 > cols_s) ? cols_s - xc_s : ws1;
        hs2 = (yc_s + hs1 > rows_s) ? rows_s - yc_s : hs1;
        act = (ws2 > 11'sd0) && (hs2 > 11'sd0);

        // scroll split: copied rows first, blank rows after
        mag_s    = (lines_s < 11'sd0) ? -lines_s : lines_s;
        part     = scroll && (mag_s < hs2);
        copy_s   = part ? hs2 - mag_s : 11'sd0;
        ystart_s = (part && lines_s < 11'sd0) ? yc_s + hs2 - 11'sd1 : yc_s;

        go = act && (!scroll || lines_reg != 8'sd0)
             && ((kind_reg == KIND_PUT) || (kind_reg == KIND_FILL)
                 || (kind_reg == KIND_READ) || scroll);
    end

    // Shared multiplier: row base of the first row, then the scroll offset
    logic [7:0]       mul_a;
    logic [IDX_W-1:0] mul_p;

    assign mul_a = (state_reg == ST_MUL_DST) ? ystart_reg : mag_reg;
    assign mul_p = {8'b0, mul_a} * {8'b0, cols};

    // Cell decision
    logic              dst_ok, src_ok, copy_now, differ, last_col, last_row;
    logic [CELL_W-1:0] new_cell;

    always_comb
    begin
        dst_ok   = dst_idx_reg < CAP_IDX;
        src_ok   = src_idx_reg < CAP_IDX;
        copy_now = copy_reg != 7'd0;
        new_cell = copy_now ? (src_ok ? rd_data_b : '0) : fill_reg;
        differ   = dst_ok && (rd_data_a != new_cell);
        last_col = col_reg == w_reg - 8'd1;
        last_row = row_reg == h_reg - 7'd1;
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        xin_next      = xin_reg;
        yin_next      = yin_reg;
        win_next      = win_reg;
        hin_next      = hin_reg;
        lines_next    = lines_reg;
        glyph_next    = glyph_reg;
        attr_next     = attr_reg;
        xc_next       = xc_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        ystart_next   = ystart_reg;
        mag_next      = mag_reg;
        copy_next     = copy_reg;
        desc_next     = desc_reg;
        read_next     = read_reg;
        fill_next     = fill_reg;
        dst_base_next = dst_base_reg;
        src_base_next = src_base_reg;
        dst_idx_next  = dst_idx_reg;
        src_idx_next  = src_idx_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        value_next    = value_reg;
        chg_next      = chg_reg;
        total_next    = total_reg;
        counter_next  = counter_reg;
        clr_next      = clr_reg;

        in_stall         = 1'b1;
        res_valid        = 1'b0;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_idx   = dst_idx_reg;
        mem_req.wr_data  = new_cell;
        mem_req.rd_idx_a = dst_idx_reg;
        mem_req.rd_idx_b = src_idx_reg;

        unique case (state_reg)
            // zero every cell after reset
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_idx  = {{(IDX_W-AW){1'b0}}, clr_reg};
                mem_req.wr_data = '0;
                clr_next        = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    kind_next  = kind;
                    xin_next   = x_pos;
                    yin_next   = y_pos;
                    win_next   = rect_width;
                    hin_next   = rect_height;
                    lines_next = scroll_lines;
                    glyph_next = glyph;
                    attr_next  = attribute;
                    state_next = ST_CLIP;
                end
            end

            ST_CLIP:
            begin
                value_next  = '0;
                chg_next    = '0;
                total_next  = '0;
                xc_next     = xc_s[7:0];
                w_next      = ws2[7:0];
                h_next      = hs2[6:0];
                ystart_next = ystart_s[7:0];
                mag_next    = mag_s[7:0];
                copy_next   = copy_s[6:0];
                desc_next   = part && (lines_s < 11'sd0);
                read_next   = kind_reg == KIND_READ;
                fill_next   = scroll ? {attr_reg, BLANK_GLYPH} : {attr_reg, glyph_reg};
                if (kind_reg == KIND_TAKE)
                begin
                    total_next   = counter_reg;
                    counter_next = '0;
                    state_next   = ST_DONE;
                end
                else if (go)
                begin
                    state_next = ST_MUL_DST;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_MUL_DST:
            begin
                dst_base_next = mul_p;
                state_next    = ST_MUL_SRC;
            end

            ST_MUL_SRC:
            begin
                src_base_next = desc_reg ? dst_base_reg - mul_p : dst_base_reg + mul_p;
                row_next      = '0;
                state_next    = ST_ROW;
            end

            ST_ROW:
            begin
                dst_idx_next = dst_base_reg + {8'b0, xc_reg};
                src_idx_next = src_base_reg + {8'b0, xc_reg};
                col_next     = '0;
                state_next   = ST_RD;
            end

            // store reads the destination and source cells
            ST_RD:
            begin
                state_next = ST_WR;
            end

            ST_WR:
            begin
                if (read_reg)
                begin
                    value_next = dst_ok ? rd_data_a : '0;
                end
                else if (differ)
                begin
                    mem_req.wr_en = 1'b1;
                    chg_next      = chg_reg + CHG_W'(1);
                    if (counter_reg != '1)
                    begin
                        counter_next = counter_reg + CNT_W'(1);
                    end
                end
                col_next     = col_reg + 8'd1;
                dst_idx_next = dst_idx_reg + IDX_W'(1);
                src_idx_next = src_idx_reg + IDX_W'(1);
                if (!last_col)
                begin
                    state_next = ST_RD;
                end
                else if (last_row)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    row_next      = row_reg + 7'd1;
                    copy_next     = copy_now ? copy_reg - 7'd1 : copy_reg;
                    dst_base_next = desc_reg ? dst_base_reg - {8'b0, cols}
                                             : dst_base_reg + {8'b0, cols};
                    src_base_next = desc_reg ? src_base_reg - {8'b0, cols}
                                             : src_base_reg + {8'b0, cols};
                    state_next    = ST_ROW;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.cell_value    = value_reg;
    assign res.changed_cells = chg_reg;
    assign res.total_writes  = total_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            counter_reg <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            clr_reg     <= clr_next;
        end
    end

    // Item and walk registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        xin_reg      <= xin_next;
        yin_reg      <= yin_next;
        win_reg      <= win_next;
        hin_reg      <= hin_next;
        lines_reg    <= lines_next;
        glyph_reg    <= glyph_next;
        attr_reg     <= attr_next;
        xc_reg       <= xc_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        ystart_reg   <= ystart_next;
        mag_reg      <= mag_next;
        copy_reg     <= copy_next;
        desc_reg     <= desc_next;
        read_reg     <= read_next;
        fill_reg     <= fill_next;
        dst_base_reg <= dst_base_next;
        src_base_reg <= src_base_next;
        dst_idx_reg  <= dst_idx_next;
        src_idx_reg  <= src_idx_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        value_reg    <= value_next;
        chg_reg      <= chg_next;
        total_reg    <= total_next;
    end

    // Writes happen only in the clearing pass or a cell step
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_WR))
        else $error("store written outside clear or cell step");

    // A cell step never writes beyond capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR && mem_req.wr_en) |-> (dst_idx_reg < CAP_IDX))
        else $error("cell write beyond capacity");

    // The write counter only drops when a take item is clipped
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLIP) |=> (counter_reg >= $past(counter_reg)))
        else $error("write counter decreased");

    // Column walk stays inside the clipped width
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (col_reg < w_reg))
        else $error("column walk past rectangle width");

endmodule

// ===== rtl/text_cell_blitter.sv =====
// text_cell_blitter: top level; configuration registers, output register,
// and the engine with its cell store. Depends on tcb_pkg, tcb_store, tcb_engine.
//
//   channel   signals                                    direction
//   in        in_valid, in_stall, kind .. attribute      item into the block
//   out       out_valid, out_stall, cell_value ..        result item out
//   cfg       cfg_write, cfg_index, cfg_data             register write
//
// Fill and scroll do each clipped cell (w, h) as a read then a compare-and-write on the
// single store write port, and on-screen put and read do one cell; take-count,
// off-screen or empty items, zero scroll and unused kinds skip the walk.
// After reset the store is zeroed one cell a cycle with in_stall high;
// configuration writes are taken meanwhile.
// A result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module text_cell_blitter
    import tcb_pkg::*;
#(
    parameter int CELL_CAPACITY = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        kind,
    input  logic signed [8:0] x_pos,
    input  logic signed [8:0] y_pos,
    input  logic signed [8:0] rect_width,
    input  logic signed [8:0] rect_height,
    input  logic signed [7:0] scroll_lines,
    input  logic [7:0]        glyph,
    input  logic [7:0]        attribute,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       cell_value,
    output logic [13:0]       changed_cells,
    output logic [31:0]       total_writes,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);

    logic [7:0] cols_reg, cols_next;
    logic [6:0] rows_reg, rows_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    mem_req_t          mem_req;
    logic [CELL_W-1:0] rd_data_a, rd_data_b;
    logic              res_valid, res_take;
    result_t           res;

    // Configuration writes
    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLUMNS: cols_next = cfg_data;
                REG_ROWS:    rows_next = cfg_data[6:0];
                default:     cols_next = cols_reg;
            endcase
        end
    end

    // Output register
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign cell_value    = out_reg.cell_value;
    assign changed_cells = out_reg.changed_cells;
    assign total_writes  = out_reg.total_writes;

    tcb_engine #(
        .CELL_CAPACITY (CELL_CAPACITY)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .scroll_lines (scroll_lines),
        .glyph        (glyph),
        .attribute    (attribute),
        .cols         (cols_reg),
        .rows         (rows_reg),
        .mem_req      (mem_req),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    tcb_store #(
        .CELL_CAPACITY (CELL_CAPACITY)
    ) u_store (
        .clk       (clk),
        .req       (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule
